/* hdl/fltp_pkg.sv */
package fltp_pkg;

  localparam int HASH_W     = 32;
  localparam int KEY_W      = 64;
  localparam int HANDLE_W   = 32;
  localparam int CNT_W      = 11;
  localparam int TOT_W      = 32;
  localparam int CNT_MAX    = (2 ** CNT_W) - 1;
  localparam int DIV_BITS   = 8;
  localparam int DIV_CYCLES = HASH_W / DIV_BITS;

  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_LOOKUP = 2'd1;
  localparam logic [1:0] FN_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_LOOKUP,
    OP_REMOVE,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } item_t;

  typedef struct packed {
    logic                valid;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  function automatic op_t classify(input logic [1:0] func);
    op_t op;
    case (func)
      FN_INSERT: op = OP_INSERT;
      FN_LOOKUP: op = OP_LOOKUP;
      FN_REMOVE: op = OP_REMOVE;
      default:   op = OP_NONE;
    endcase
    return op;
  endfunction

  function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] a,
                                               input logic [TOT_W-1:0] b);
    logic [TOT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TOT_W] ? {TOT_W{1'b1}} : s[TOT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_cnt(input logic [31:0] v);
    return (v > 32'(CNT_MAX)) ? CNT_W'(CNT_MAX) : v[CNT_W-1:0];
  endfunction

endpackage

/* hdl/flow_table_linear_probe_unit.sv */
// Channel   Direction  Handshake             Payload
// in_       input      in_valid/in_ready     func, key_hash, flow_key, flow_handle
// out_      output     out_valid/out_ready   status, found_handle, probe_count,
//                                            entry_count, insert/lookup totals
// cfg_      input      cfg_wr_en             active_slots (11 bits)
//
// Front computes hash mod capacity, 8 hash bits a cycle.
// Back reads the home slot and then each further probed slot, one registered read of the
// slot memory for each; a two-entry queue overlaps both.
// After reset a clearing pass over all TABLE_DEPTH slots runs; in_ready is low meanwhile.
// A waiting result sits in the output register while the next transaction is probed.
module flow_table_linear_probe_unit #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [10:0]                   cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_func,
  input  logic [fltp_pkg::HASH_W-1:0]   in_key_hash,
  input  logic [fltp_pkg::KEY_W-1:0]    in_flow_key,
  input  logic [fltp_pkg::HANDLE_W-1:0] in_flow_handle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [fltp_pkg::HANDLE_W-1:0] out_found_handle,
  output logic [fltp_pkg::CNT_W-1:0]    out_probe_count,
  output logic [fltp_pkg::CNT_W-1:0]    out_entry_count,
  output logic [fltp_pkg::TOT_W-1:0]    out_insert_probe_total,
  output logic [fltp_pkg::TOT_W-1:0]    out_lookup_probe_total
);

  localparam int AW      = $clog2(TABLE_DEPTH);
  localparam int CAPW    = $clog2(TABLE_DEPTH + 1);
  localparam int QW      = $bits(fltp_pkg::item_t) + AW;
  localparam int CAP_RST = (TABLE_DEPTH < 1024) ? TABLE_DEPTH : 1024;

  logic [CAPW-1:0] cap_r, cap_nxt;
  logic            clear_busy, q_push, q_pop, q_full, q_empty;
  logic [QW-1:0]   q_wdata, q_rdata;

  // clamp the written capacity into 1..TABLE_DEPTH
  always_comb begin
    if (cfg_wr_data == '0) begin
      cap_nxt = CAPW'(1);
    end else if (32'(cfg_wr_data) > 32'(TABLE_DEPTH)) begin
      cap_nxt = CAPW'(TABLE_DEPTH);
    end else begin
      cap_nxt = CAPW'(cfg_wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAPW'(CAP_RST);
    end else if (cfg_wr_en) begin
      cap_r <= cap_nxt;
    end
  end

  fltp_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cap_i          (cap_r),
    .clear_busy_i   (clear_busy),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_key_hash    (in_key_hash),
    .in_flow_key    (in_flow_key),
    .in_flow_handle (in_flow_handle),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_data_o       (q_wdata)
  );

  fltp_queue #(.WIDTH(QW)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  fltp_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cap_i                  (cap_r),
    .q_empty_i              (q_empty),
    .q_data_i               (q_rdata),
    .q_pop_o                (q_pop),
    .clear_busy_o           (clear_busy),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_status             (out_status),
    .out_found_handle       (out_found_handle),
    .out_probe_count        (out_probe_count),
    .out_entry_count        (out_entry_count),
    .out_insert_probe_total (out_insert_probe_total),
    .out_lookup_probe_total (out_lookup_probe_total)
  );

endmodule

/* hdl/fltp_ram.sv */
module fltp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/fltp_front.sv */
module fltp_front #(
  parameter int TABLE_DEPTH = 1024,
  localparam int AW = $clog2(TABLE_DEPTH),
  localparam int CAPW = $clog2(TABLE_DEPTH + 1),
  localparam int QW = $bits(fltp_pkg::item_t) + AW
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [CAPW-1:0]               cap_i,
  input  logic                          clear_busy_i,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_func,
  input  logic [fltp_pkg::HASH_W-1:0]   in_key_hash,
  input  logic [fltp_pkg::KEY_W-1:0]    in_flow_key,
  input  logic [fltp_pkg::HANDLE_W-1:0] in_flow_handle,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output logic [QW-1:0]                 q_data_o
);

  localparam int CW = (fltp_pkg::DIV_CYCLES > 1) ? $clog2(fltp_pkg::DIV_CYCLES) : 1;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} state_t;

  state_t                        state_r, state_nxt;
  logic [fltp_pkg::HASH_W-1:0]   hash_r, hash_nxt;
  logic [CAPW-1:0]               rem_r, rem_nxt, rem_v;
  logic [CAPW:0]                 trial;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  fltp_pkg::item_t               item_r, item_nxt;

  // remainder of hash by capacity, one byte of the hash per cycle
  always_comb begin
    rem_v = rem_r;
    trial = '0;
    for (int i = 0; i < fltp_pkg::DIV_BITS; i++) begin
      trial = {rem_v, hash_r[fltp_pkg::HASH_W-1-i]};
      if (trial >= {1'b0, cap_i}) begin
        trial = trial - {1'b0, cap_i};
      end
      rem_v = trial[CAPW-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    hash_nxt  = hash_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    item_nxt  = item_r;
    in_ready  = 1'b0;
    q_push_o  = 1'b0;
    case (state_r)
      F_IDLE: begin
        in_ready = !clear_busy_i;
        if (in_valid && !clear_busy_i) begin
          hash_nxt        = in_key_hash;
          rem_nxt         = '0;
          cnt_nxt         = '0;
          item_nxt.op     = fltp_pkg::classify(in_func);
          item_nxt.key    = in_flow_key;
          item_nxt.handle = in_flow_handle;
          state_nxt       = F_DIV;
        end
      end
      F_DIV: begin
        rem_nxt  = rem_v;
        hash_nxt = hash_r << fltp_pkg::DIV_BITS;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CW'(fltp_pkg::DIV_CYCLES - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        // hold until the queue has room
        q_push_o = !q_full_i;
        if (!q_full_i) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  assign q_data_o = {rem_r[AW-1:0], item_r};

  always_ff @(posedge clk) begin
    hash_r <= hash_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    item_r <= item_nxt;
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hdl/fltp_queue.sv */
module fltp_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;

  assign full_o  = (cnt_r == 2'd2);
  assign empty_o = (cnt_r == 2'd0);
  assign data_o  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wp_r] <= data_i;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_i) begin
        wp_r <= ~wp_r;
      end
      if (pop_i) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

/* hdl/fltp_back.sv */
module fltp_back #(
  parameter int TABLE_DEPTH = 1024,
  localparam int AW = $clog2(TABLE_DEPTH),
  localparam int CAPW = $clog2(TABLE_DEPTH + 1),
  localparam int QW = $bits(fltp_pkg::item_t) + AW
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [CAPW-1:0]               cap_i,
  input  logic                          q_empty_i,
  input  logic [QW-1:0]                 q_data_i,
  output logic                          q_pop_o,
  output logic                          clear_busy_o,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [fltp_pkg::HANDLE_W-1:0] out_found_handle,
  output logic [fltp_pkg::CNT_W-1:0]    out_probe_count,
  output logic [fltp_pkg::CNT_W-1:0]    out_entry_count,
  output logic [fltp_pkg::TOT_W-1:0]    out_insert_probe_total,
  output logic [fltp_pkg::TOT_W-1:0]    out_lookup_probe_total
);

  localparam int EW = $bits(fltp_pkg::entry_t);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_CHECK, S_FIN} state_t;

  state_t                        state_r, state_nxt;
  logic [AW-1:0]                 clr_r, clr_nxt;
  fltp_pkg::item_t               item_r, item_nxt, q_item;
  logic [AW-1:0]                 q_home;
  logic [AW-1:0]                 cur_r, cur_nxt;
  logic [CAPW-1:0]               att_r, att_nxt;
  logic [CAPW-1:0]               occ_r, occ_nxt;
  logic [fltp_pkg::TOT_W-1:0]    ins_tot_r, ins_tot_nxt;
  logic [fltp_pkg::TOT_W-1:0]    lk_tot_r, lk_tot_nxt;
  logic [1:0]                    res_status_r, res_status_nxt;
  logic [fltp_pkg::HANDLE_W-1:0] res_found_r, res_found_nxt;
  logic [CAPW-1:0]               res_probe_r, res_probe_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [1:0]                    out_status_r, out_status_nxt;
  logic [fltp_pkg::HANDLE_W-1:0] out_found_r, out_found_nxt;
  logic [fltp_pkg::CNT_W-1:0]    out_probe_r, out_probe_nxt;
  logic [fltp_pkg::CNT_W-1:0]    out_entry_r, out_entry_nxt;
  logic [fltp_pkg::TOT_W-1:0]    out_ins_r, out_ins_nxt;
  logic [fltp_pkg::TOT_W-1:0]    out_lk_r, out_lk_nxt;

  logic                          ram_we, ram_re;
  logic [AW-1:0]                 ram_waddr;
  fltp_pkg::entry_t              ram_wdata, rd;
  logic [EW-1:0]                 ram_rdata;
  logic                          last, hit;

  fltp_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cur_r),
    .rdata (ram_rdata)
  );

  assign q_item = q_data_i[$bits(fltp_pkg::item_t)-1:0];
  assign q_home = q_data_i[QW-1 -: AW];
  assign rd     = ram_rdata;
  assign last   = (att_r == cap_i - 1'b1);
  assign hit    = (rd.key == item_r.key);

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    item_nxt       = item_r;
    cur_nxt        = cur_r;
    att_nxt        = att_r;
    occ_nxt        = occ_r;
    ins_tot_nxt    = ins_tot_r;
    lk_tot_nxt     = lk_tot_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_probe_nxt  = res_probe_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_probe_nxt  = out_probe_r;
    out_entry_nxt  = out_entry_r;
    out_ins_nxt    = out_ins_r;
    out_lk_nxt     = out_lk_r;
    q_pop_o        = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = cur_r;
    ram_wdata      = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == AW'(TABLE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o        = 1'b1;
          item_nxt       = q_item;
          cur_nxt        = q_home;
          att_nxt        = '0;
          res_found_nxt  = '0;
          res_probe_nxt  = '0;
          res_status_nxt = fltp_pkg::ST_NOT_FOUND;
          if (q_item.op == fltp_pkg::OP_NONE) begin
            state_nxt = S_FIN;
          end else if (q_item.op == fltp_pkg::OP_INSERT && occ_r >= cap_i) begin
            res_status_nxt = fltp_pkg::ST_FULL;
            state_nxt      = S_FIN;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        ram_re    = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        // advance to the next slot, wrapping to slot 0 at capacity, also when this one ends the probe
        att_nxt   = att_r + 1'b1;
        cur_nxt   = (CAPW'(cur_r) == cap_i - 1'b1) ? '0 : cur_r + 1'b1;
        state_nxt = S_READ;
        case (item_r.op)
          fltp_pkg::OP_INSERT: begin
            if (!rd.valid) begin
              ram_we           = 1'b1;
              ram_wdata.valid  = 1'b1;
              ram_wdata.key    = item_r.key;
              ram_wdata.handle = item_r.handle;
              occ_nxt          = occ_r + 1'b1;
              ins_tot_nxt      = fltp_pkg::sat_add(ins_tot_r, 32'(att_r));
              res_probe_nxt    = att_r;
              res_status_nxt   = fltp_pkg::ST_OK;
              state_nxt        = S_FIN;
            end else if (last) begin
              res_status_nxt = fltp_pkg::ST_FULL;
              state_nxt      = S_FIN;
            end
          end
          fltp_pkg::OP_LOOKUP: begin
            if (!rd.valid) begin
              res_probe_nxt = att_r;
              state_nxt     = S_FIN;
            end else if (hit) begin
              res_found_nxt  = rd.handle;
              lk_tot_nxt     = fltp_pkg::sat_add(lk_tot_r, 32'(att_r));
              res_probe_nxt  = att_r;
              res_status_nxt = fltp_pkg::ST_OK;
              state_nxt      = S_FIN;
            end else if (last) begin
              res_probe_nxt = att_r;
              state_nxt     = S_FIN;
            end
          end
          fltp_pkg::OP_REMOVE: begin
            if (rd.valid && hit) begin
              ram_we         = 1'b1;
              occ_nxt        = (occ_r != '0) ? occ_r - 1'b1 : occ_r;
              res_probe_nxt  = att_r;
              res_status_nxt = fltp_pkg::ST_OK;
              state_nxt      = S_FIN;
            end else if (last) begin
              res_probe_nxt = att_r;
              state_nxt     = S_FIN;
            end
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = res_found_r;
          out_probe_nxt  = fltp_pkg::sat_cnt(32'(res_probe_r));
          out_entry_nxt  = fltp_pkg::sat_cnt(32'(occ_r));
          out_ins_nxt    = ins_tot_r;
          out_lk_nxt     = lk_tot_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    cur_r        <= cur_nxt;
    att_r        <= att_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_probe_r  <= res_probe_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_probe_r  <= out_probe_nxt;
    out_entry_r  <= out_entry_nxt;
    out_ins_r    <= out_ins_nxt;
    out_lk_r     <= out_lk_nxt;
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      occ_r       <= '0;
      ins_tot_r   <= '0;
      lk_tot_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      occ_r       <= occ_nxt;
      ins_tot_r   <= ins_tot_nxt;
      lk_tot_r    <= lk_tot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign clear_busy_o           = (state_r == S_CLEAR);
  assign out_valid              = out_valid_r;
  assign out_status             = out_status_r;
  assign out_found_handle       = out_found_r;
  assign out_probe_count        = out_probe_r;
  assign out_entry_count        = out_entry_r;
  assign out_insert_probe_total = out_ins_r;
  assign out_lookup_probe_total = out_lk_r;

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !q_pop_o)
    else $error("queue popped during clearing pass");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CAPW'(TABLE_DEPTH))
    else $error("occupied count beyond table depth");

  a_ram_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("slot read and write in one cycle");

  a_att_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> (att_r < cap_i))
    else $error("probe walked past capacity");

endmodule
